[rtl/staggered_voice_pcm_mixer_macros.svh]
// Assertion helpers for the mixer.
`ifndef STAGGERED_VOICE_PCM_MIXER_MACROS_SVH
`define STAGGERED_VOICE_PCM_MIXER_MACROS_SVH

// same-cycle implication
`define SVPM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svpm assertion failed");

// next-cycle implication
`define SVPM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("svpm assertion failed");

`endif

[rtl/svpm_pkg.sv]
package svpm_pkg;

   localparam int VOICES_DEF      = 8;
   localparam int CLIP_FRAMES_DEF = 4096;

   localparam int SAMPLE_W  = 16;
   localparam int CURSOR_W  = 20;
   localparam int OUT_W     = 20;
   localparam int OUT_MAX   = 524287;
   localparam int OUT_MIN   = -524288;
   localparam int ROUND_OFF = 16384;
   localparam int Q_SHIFT   = 15;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_FRAME = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_VOLUME     = 3'd0,
      REG_STAGGER    = 3'd1,
      REG_VOICE_CNT  = 3'd2,
      REG_LENGTH_A   = 3'd3,
      REG_LENGTH_B   = 3'd4,
      REG_CHANNELS_A = 3'd5,
      REG_CHANNELS_B = 3'd6
   } reg_type;

   typedef struct packed {
      logic valid;
      logic ph;
      logic ena;
      logic enb;
   } issue_type;

endpackage

[rtl/svpm_ram.sv]
module svpm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/staggered_voice_pcm_mixer.sv]
// channel  ports   dir  payload
// -------  ------  ---  -----------------------------------------------
// request  req_*   in   tuser op/clip_select/channel, tdata frame/sample
// result   rsp_*   out  tdata left/right sample, tuser stereo/active
// config   csr_*   in   APB registers at byte address 4*i
//
// Load and start items complete on acceptance. A frame item holds the input (req_tready low)
// through acceptance, two clip-memory reads per voice, one per channel, the drain of the
// multiply pipeline and the output; with playback off it goes straight to the output.
// Reset clears control state and configuration registers; the clip memories are not cleared.
// A result waits in the output register; a frame stalls there until it drains.
`include "staggered_voice_pcm_mixer_macros.svh"

module staggered_voice_pcm_mixer
   import svpm_pkg::*;
#(
   parameter int VOICES      = VOICES_DEF,
   parameter int CLIP_FRAMES = CLIP_FRAMES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // frame_index[11:0], sample_value[27:12]
   input  logic [3:0]  req_tuser,   // op[1:0], clip_select[2], channel[3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // left_sample[19:0], right_sample[39:20]
   output logic [1:0]  rsp_tuser,   // stereo[0], active[1]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ADDR_W = $clog2(2 * CLIP_FRAMES);
   localparam int FRM_W  = $clog2(CLIP_FRAMES);
   localparam int LEN_W  = $clog2(CLIP_FRAMES + 1);
   localparam int CMP_W  = (LEN_W > 13) ? LEN_W : 13;
   localparam int VC_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int VN_W   = $clog2(VOICES + 1);
   localparam int NC_W   = (VN_W > 4) ? VN_W : 4;
   localparam int OFF_W  = 16 + $clog2(VOICES);
   localparam int LOC_W  = ((OFF_W > CURSOR_W) ? OFF_W : CURSOR_W) + 1;
   localparam int ACC_W  = 33 + $clog2(VOICES);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_DRAIN = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   // configuration
   logic [15:0] volume_ff, stagger_ff;
   logic [3:0]  vcount_ff;
   logic [12:0] len_a_ff, len_b_ff;
   logic [1:0]  cha_ff, chb_ff;
   logic        csr_write;
   reg_type     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff  <= 16'd32768;
         stagger_ff <= 16'd24000;
         vcount_ff  <= 4'd1;
         len_a_ff   <= '0;
         len_b_ff   <= '0;
         cha_ff     <= '0;
         chb_ff     <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            REG_VOLUME:     volume_ff  <= csr_pwdata[15:0];
            REG_STAGGER:    stagger_ff <= csr_pwdata[15:0];
            REG_VOICE_CNT:  vcount_ff  <= csr_pwdata[3:0];
            REG_LENGTH_A:   len_a_ff   <= csr_pwdata[12:0];
            REG_LENGTH_B:   len_b_ff   <= csr_pwdata[12:0];
            REG_CHANNELS_A: cha_ff     <= csr_pwdata[1:0];
            REG_CHANNELS_B: chb_ff     <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_VOLUME:     csr_prdata = 32'(volume_ff);
         REG_STAGGER:    csr_prdata = 32'(stagger_ff);
         REG_VOICE_CNT:  csr_prdata = 32'(vcount_ff);
         REG_LENGTH_A:   csr_prdata = 32'(len_a_ff);
         REG_LENGTH_B:   csr_prdata = 32'(len_b_ff);
         REG_CHANNELS_A: csr_prdata = 32'(cha_ff);
         REG_CHANNELS_B: csr_prdata = 32'(chb_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // clip properties
   logic             lda, ldb, sta, stb, stereo;
   logic [CMP_W-1:0] la, lb, la_raw, lb_raw;

   assign lda    = |cha_ff;
   assign ldb    = |chb_ff;
   assign sta    = cha_ff[1];
   assign stb    = chb_ff[1];
   assign stereo = sta | stb;
   assign la_raw = CMP_W'(len_a_ff);
   assign lb_raw = CMP_W'(len_b_ff);
   assign la     = (la_raw > CMP_W'(CLIP_FRAMES)) ? CMP_W'(CLIP_FRAMES) : la_raw;
   assign lb     = (lb_raw > CMP_W'(CLIP_FRAMES)) ? CMP_W'(CLIP_FRAMES) : lb_raw;

   // request decode
   op_type           req_op;
   logic             req_sel, req_ch, req_accept, fi_ok;
   logic [11:0]      req_fi;
   logic [15:0]      req_sample;
   logic [ADDR_W-1:0] waddr;
   logic             we_a, we_b;

   assign req_op     = op_type'(req_tuser[1:0]);
   assign req_sel    = req_tuser[2];
   assign req_ch     = req_tuser[3];
   assign req_fi     = req_tdata[11:0];
   assign req_sample = req_tdata[27:12];
   assign req_accept = req_tvalid & req_tready;
   assign fi_ok      = CMP_W'(req_fi) < CMP_W'(CLIP_FRAMES);
   assign waddr      = req_ch ? ADDR_W'(CLIP_FRAMES) + ADDR_W'(req_fi) : ADDR_W'(req_fi);
   assign we_a       = req_accept && (req_op == OP_LOAD) && fi_ok && !req_sel;
   assign we_b       = req_accept && (req_op == OP_LOAD) && fi_ok && req_sel;

   // control state
   state_type               state_ff, state_in;
   logic [CURSOR_W-1:0]     cursor_ff, cursor_in;
   logic [VOICES-1:0]       playing_ff, playing_in;
   logic                    play_on_ff, play_on_in;
   logic [VC_W-1:0]         v_ff, v_in;
   logic                    ph_ff, ph_in;
   logic [OFF_W-1:0]        off_ff, off_in;
   logic                    any_ff, any_in;
   logic                    zmode_ff, zmode_in;
   issue_type               s1_ff, s1_in;
   logic                    p2_valid_ff, p2_ph_ff;
   logic signed [31:0]      prod_a_ff, prod_b_ff;
   logic signed [ACC_W-1:0] acc_l_ff, acc_r_ff, acc_l_in, acc_r_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]        left_ff, right_ff, left_in, right_in;
   logic                    stereo_ff, active_ff, stereo_in, active_in;
   logic                    out_load;

   // per-voice position
   logic [LOC_W-1:0]  local_u, local_p1;
   logic              in_a, in_b, still_a, still_b, done, pl;
   logic [ADDR_W-1:0] raddr;
   logic [FRM_W-1:0]  pos;
   logic [NC_W-1:0]   n_arm;

   assign local_u  = LOC_W'(cursor_ff) - LOC_W'(off_ff);
   assign local_p1 = local_u + LOC_W'(1);
   assign in_a     = !local_u[LOC_W-1] && (local_u < LOC_W'(la));
   assign in_b     = !local_u[LOC_W-1] && (local_u < LOC_W'(lb));
   assign still_a  = lda && (local_p1[LOC_W-1] || (local_p1 < LOC_W'(la)));
   assign still_b  = ldb && (local_p1[LOC_W-1] || (local_p1 < LOC_W'(lb)));
   assign done     = !still_a && !still_b;
   assign pl       = playing_ff[v_ff];
   assign pos      = local_u[FRM_W-1:0];
   assign raddr    = ph_ff ? ADDR_W'(CLIP_FRAMES) + ADDR_W'(pos) : ADDR_W'(pos);
   assign n_arm    = (vcount_ff == 4'd0) ? NC_W'(1) :
                     (NC_W'(vcount_ff) > NC_W'(VOICES)) ? NC_W'(VOICES) : NC_W'(vcount_ff);

   logic [15:0] rd_a, rd_b;

   svpm_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 * CLIP_FRAMES)) u_clip_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr),
      .wdata (req_sample),
      .raddr (raddr),
      .rdata (rd_a)
   );

   svpm_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 * CLIP_FRAMES)) u_clip_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr),
      .wdata (req_sample),
      .raddr (raddr),
      .rdata (rd_b)
   );

   // multiply stage
   logic signed [32:0] mult_a, mult_b;
   logic signed [32:0] vol_s;

   assign vol_s  = 33'(signed'({1'b0, volume_ff}));
   assign mult_a = 33'(signed'(rd_a)) * vol_s;
   assign mult_b = 33'(signed'(rd_b)) * vol_s;

   always_ff @(posedge clock) begin
      prod_a_ff <= s1_ff.ena ? signed'(mult_a[31:0]) : '0;
      prod_b_ff <= s1_ff.enb ? signed'(mult_b[31:0]) : '0;
      p2_ph_ff  <= s1_ff.ph;
   end

   // rounding and saturation
   function automatic logic [OUT_W-1:0] scale_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      logic signed [ACC_W-1:0] q;
      t = acc + ACC_W'(ROUND_OFF);
      q = t >>> Q_SHIFT;
      if (q > ACC_W'(OUT_MAX)) begin
         scale_sat = OUT_W'(OUT_MAX);
      end else if (q < ACC_W'(OUT_MIN)) begin
         scale_sat = OUT_W'(OUT_MIN);
      end else begin
         scale_sat = q[OUT_W-1:0];
      end
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign out_load   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      cursor_in  = cursor_ff;
      playing_in = playing_ff;
      play_on_in = play_on_ff;
      v_in       = v_ff;
      ph_in      = ph_ff;
      off_in     = off_ff;
      any_in     = any_ff;
      zmode_in   = zmode_ff;
      s1_in      = '0;
      acc_l_in   = acc_l_ff;
      acc_r_in   = acc_r_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      stereo_in  = stereo_ff;
      active_in  = active_ff;

      if (p2_valid_ff) begin
         if (p2_ph_ff) begin
            acc_r_in = acc_r_ff + ACC_W'(prod_a_ff) + ACC_W'(prod_b_ff);
         end else begin
            acc_l_in = acc_l_ff + ACC_W'(prod_a_ff) + ACC_W'(prod_b_ff);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_START: begin
                     for (int i = 0; i < VOICES; i++) begin
                        playing_in[i] = NC_W'(i) < n_arm;
                     end
                     cursor_in  = '0;
                     play_on_in = lda | ldb;
                  end
                  OP_FRAME: begin
                     if (!play_on_ff || !(lda || ldb)) begin
                        zmode_in = 1'b1;
                        state_in = S_EMIT;
                     end else begin
                        zmode_in = 1'b0;
                        v_in     = '0;
                        ph_in    = 1'b0;
                        off_in   = '0;
                        any_in   = 1'b0;
                        acc_l_in = '0;
                        acc_r_in = '0;
                        state_in = S_ISSUE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ISSUE: begin
            s1_in.valid = 1'b1;
            s1_in.ph    = ph_ff;
            if (!ph_ff) begin
               s1_in.ena = pl && lda && in_a;
               s1_in.enb = pl && ldb && in_b;
               if (pl) begin
                  if ((lda && in_a) || (ldb && in_b) || !done) begin
                     any_in = 1'b1;
                  end
               end
               ph_in = 1'b1;
            end else begin
               s1_in.ena = pl && sta && in_a;
               s1_in.enb = pl && stb && in_b;
               // the voice stays on until its right channel is read too
               if (pl && done) begin
                  playing_in[v_ff] = 1'b0;
               end
               ph_in  = 1'b0;
               off_in = off_ff + OFF_W'(stagger_ff);
               v_in   = v_ff + VC_W'(1);
               if (v_ff == VC_W'(VOICES - 1)) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (!s1_ff.valid && !p2_valid_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_load) begin
               if (zmode_ff || !any_ff) begin
                  left_in   = '0;
                  right_in  = '0;
                  stereo_in = 1'b0;
                  active_in = 1'b0;
                  if (!zmode_ff) begin
                     play_on_in = 1'b0;
                  end
               end else begin
                  left_in   = scale_sat(acc_l_ff);
                  right_in  = stereo ? scale_sat(acc_r_ff) : '0;
                  stereo_in = stereo;
                  active_in = 1'b1;
                  if (cursor_ff != '1) begin
                     cursor_in = cursor_ff + CURSOR_W'(1);
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         playing_ff   <= '0;
         play_on_ff   <= 1'b0;
         v_ff         <= '0;
         ph_ff        <= 1'b0;
         off_ff       <= '0;
         any_ff       <= 1'b0;
         zmode_ff     <= 1'b0;
         s1_ff        <= '0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         playing_ff   <= playing_in;
         play_on_ff   <= play_on_in;
         v_ff         <= v_in;
         ph_ff        <= ph_in;
         off_ff       <= off_in;
         any_ff       <= any_in;
         zmode_ff     <= zmode_in;
         s1_ff        <= s1_in;
         p2_valid_ff  <= s1_ff.valid;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_l_ff  <= acc_l_in;
      acc_r_ff  <= acc_r_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      stereo_ff <= stereo_in;
      active_ff <= active_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {right_ff, left_ff};
   assign rsp_tuser  = {active_ff, stereo_ff};

   `SVPM_ASSERT_IMP(a_emit_drained, clock, reset, state_ff == S_EMIT,
                    !s1_ff.valid && !p2_valid_ff)
   `SVPM_ASSERT_IMP(a_mac_in_frame, clock, reset, p2_valid_ff,
                    state_ff == S_ISSUE || state_ff == S_DRAIN)
   `SVPM_ASSERT_IMP(a_active_needs_play, clock, reset, out_load && active_in, play_on_ff)
   `SVPM_ASSERT_NXT(a_cursor_idle, clock, reset, state_ff == S_ISSUE, $stable(cursor_ff))

endmodule
